### sv/ptu_pkg.sv
// ---------------------------------------------------------------------------
// ptu_pkg: shared types and constants of the particle table
// Table size, index widths, action and result codes, the stored particle
// record and the command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package ptu_pkg;

  // table size and the widths that follow from it
  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // input action codes; code 3 is unused and ignored
  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_CLEAR = 2'd2
  } ptu_action_t;

  // result status codes
  typedef enum logic [2:0] {
    RES_ADDED   = 3'd0,
    RES_FULL    = 3'd1,
    RES_CLEARED = 3'd2,
    RES_LIVE    = 3'd3,
    RES_NONE    = 3'd4
  } ptu_result_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_CLEAR,
    S_READ,
    S_EVAL,
    S_FINISH
  } ptu_state_t;

  // one stored particle
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] life;
    logic [31:0] birth;
    logic [31:0] color;
  } ptu_part_t;

  // controller to datapath
  typedef struct packed {
    logic        capture;     // latch the input beat, reset walk counters
    logic        add_store;   // write new particle at the fill level
    logic        clear;       // empty the table
    logic        emit_simple; // send a one-beat result with emit_code
    ptu_result_t emit_code;
    logic        rd_en;       // read the entry under the walk index
    logic        keep;        // write back a survivor, park it as pending
    logic        idx_adv;     // step the walk index
    logic        fin;         // send the final beat of a tick, commit count
  } ptu_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_full;
    logic cnt_zero;
    logic last_idx;
    logic survive;
    logic pend_valid;
    logic out_free;
  } ptu_sts_t;

endpackage

### sv/particle_table_update.sv
// ---------------------------------------------------------------------------
// particle_table_update: fixed-capacity particle table with lifetime expiry
// Stores particles on add, moves, expires and compacts them on tick, and
// empties the table on clear.
// ---------------------------------------------------------------------------
// Use:
//   The input channel (in_valid/in_stall) takes one action beat at a time;
//   in_stall is low only while the block is idle. The result channel
//   (out_valid/out_stall) gives one beat per add, refusal or clear, and one
//   beat per surviving particle on a tick (or one "none live" beat), with
//   out_last_item set on the final beat of each action.
//   Add and clear: the result beat loads from the add or clear state once
//   the output register is free, and the block returns to idle as it loads,
//   so it takes one such action at a time.
//   Tick: the walk over the stored particles reads one entry from the
//   particle memory and evaluates it in the next cycle, one entry at a
//   time. Each survivor's beat leaves once the next survivor is found; the
//   last one at the end.
//   A stalled result holds in the output register; the walk pauses only
//   when a further beat must be loaded behind it.
//   Reset empties the table and drops any result held. Entries need no
//   clearing pass: only entries below the fill count are ever read.
// ---------------------------------------------------------------------------
module particle_table_update (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [31:0]        in_now_ms,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_vel_x,
  input  logic signed [15:0] in_vel_y,
  input  logic [15:0]        in_life_ms,
  input  logic [31:0]        in_part_color,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic [31:0]        out_color,
  output logic               out_last_item
);
  import ptu_pkg::*;

  ptu_cmd_t cmd;
  ptu_sts_t sts;

  // sequencer
  ptu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // storage and arithmetic
  ptu_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_now_ms     (in_now_ms),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_vel_x      (in_vel_x),
    .in_vel_y      (in_vel_y),
    .in_life_ms    (in_life_ms),
    .in_part_color (in_part_color),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_color     (out_color),
    .out_last_item (out_last_item)
  );

endmodule

### sv/ptu_ctrl.sv
// ---------------------------------------------------------------------------
// ptu_ctrl: sequencer of the particle table
// Accepts one input beat at a time, then steps the datapath through an add,
// a clear or a walk over the stored particles for a tick.
// ---------------------------------------------------------------------------
module ptu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_action,
  output logic              in_stall,
  input  ptu_pkg::ptu_sts_t sts,
  output ptu_pkg::ptu_cmd_t cmd
);
  import ptu_pkg::*;

  ptu_state_t state_r;
  ptu_state_t state_nxt;
  logic       eval_wait;

  // a survivor with a pending one ahead needs a free output register
  assign eval_wait = sts.survive && sts.pend_valid && !sts.out_free;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_action)
            ACT_ADD:   state_nxt = S_ADD;
            ACT_TICK:  state_nxt = sts.cnt_zero ? S_FINISH : S_READ;
            ACT_CLEAR: state_nxt = S_CLEAR;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      S_CLEAR: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!eval_wait) state_nxt = sts.last_idx ? S_FINISH : S_READ;
      end
      S_FINISH: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_ADD: begin
        if (sts.out_free) begin
          cmd.emit_simple = 1'b1;
          cmd.add_store   = !sts.cnt_full;
          cmd.emit_code   = sts.cnt_full ? RES_FULL : RES_ADDED;
        end
      end
      S_CLEAR: begin
        if (sts.out_free) begin
          cmd.emit_simple = 1'b1;
          cmd.clear       = 1'b1;
          cmd.emit_code   = RES_CLEARED;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
      end
      S_EVAL: begin
        if (!eval_wait) begin
          cmd.keep    = sts.survive;
          cmd.idx_adv = 1'b1;
        end
      end
      S_FINISH: begin
        cmd.fin = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

### sv/ptu_dp.sv
// ---------------------------------------------------------------------------
// ptu_dp: datapath of the particle table
// Particle memory, fill count, walk counters, survivor update and expiry
// check, the one-deep pending survivor and the output register.
// ---------------------------------------------------------------------------
module ptu_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  ptu_pkg::ptu_cmd_t  cmd,
  output ptu_pkg::ptu_sts_t  sts,
  input  logic [31:0]        in_now_ms,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_vel_x,
  input  logic signed [15:0] in_vel_y,
  input  logic [15:0]        in_life_ms,
  input  logic [31:0]        in_part_color,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic [31:0]        out_color,
  output logic               out_last_item
);
  import ptu_pkg::*;

  // storage
  ptu_part_t  mem [CAPACITY];
  ptu_part_t  rd_q_r;
  ptu_part_t  new_r;

  // control registers
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] wr_r, wr_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload registers
  logic [15:0]      pend_x_r, pend_y_r;
  logic [31:0]      pend_color_r;
  logic [2:0]       out_status_r, out_status_nxt;
  logic [15:0]      out_x_r, out_x_nxt;
  logic [15:0]      out_y_r, out_y_nxt;
  logic [31:0]      out_color_r, out_color_nxt;
  logic             out_last_r, out_last_nxt;

  logic [15:0]      nx, ny;
  logic [32:0]      limit;
  logic             survive;
  ptu_part_t        upd;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  ptu_part_t        mem_wdata;
  logic [CNT_W-1:0] idx_inc;
  logic             out_free;
  logic             out_load;

  // move the entry and check its expiry against the tick time
  assign nx      = rd_q_r.x + rd_q_r.vx;
  assign ny      = rd_q_r.y + rd_q_r.vy;
  assign limit   = {1'b0, rd_q_r.birth} + {17'd0, rd_q_r.life};
  assign survive = !({1'b0, new_r.birth} > limit);

  always_comb begin
    upd   = rd_q_r;
    upd.x = nx;
    upd.y = ny;
  end

  // memory write: new particle on add, compacted survivor on tick
  assign mem_we    = cmd.add_store || cmd.keep;
  assign mem_waddr = cmd.keep ? wr_r[IDX_W-1:0] : count_r[IDX_W-1:0];
  assign mem_wdata = cmd.keep ? upd : new_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.rd_en) rd_q_r <= mem[idx_r[IDX_W-1:0]];
  end

  // latch the accepted beat; its time serves as birth or tick reference
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      new_r.x     <= in_pos_x;
      new_r.y     <= in_pos_y;
      new_r.vx    <= in_vel_x;
      new_r.vy    <= in_vel_y;
      new_r.life  <= in_life_ms;
      new_r.birth <= in_now_ms;
      new_r.color <= in_part_color;
    end
  end

  // fill count and walk counters
  assign idx_inc = idx_r + CNT_W'(1);

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.add_store) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.fin) begin
      count_nxt = wr_r;
    end
  end

  always_comb begin
    idx_nxt        = idx_r;
    wr_nxt         = wr_r;
    pend_valid_nxt = pend_valid_r;
    if (cmd.capture) begin
      idx_nxt        = '0;
      wr_nxt         = '0;
      pend_valid_nxt = 1'b0;
    end else begin
      if (cmd.idx_adv) idx_nxt = idx_inc;
      if (cmd.keep) begin
        wr_nxt         = wr_r + CNT_W'(1);
        pend_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      idx_r        <= '0;
      wr_r         <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      idx_r        <= idx_nxt;
      wr_r         <= wr_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // park the newest survivor until the next one shows whether it is last
  always_ff @(posedge clk) begin
    if (cmd.keep) begin
      pend_x_r     <= nx;
      pend_y_r     <= ny;
      pend_color_r <= rd_q_r.color;
    end
  end

  // output register: load a beat when free, hold while stalled
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = cmd.emit_simple || (cmd.keep && pend_valid_r) || cmd.fin;
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_comb begin
    out_status_nxt = RES_LIVE;
    out_x_nxt      = pend_x_r;
    out_y_nxt      = pend_y_r;
    out_color_nxt  = pend_color_r;
    out_last_nxt   = 1'b0;
    if (cmd.emit_simple) begin
      out_status_nxt = cmd.emit_code;
      out_x_nxt      = '0;
      out_y_nxt      = '0;
      out_color_nxt  = '0;
      out_last_nxt   = 1'b1;
    end else if (cmd.fin) begin
      out_last_nxt = 1'b1;
      if (!pend_valid_r) begin
        out_status_nxt = RES_NONE;
        out_x_nxt      = '0;
        out_y_nxt      = '0;
        out_color_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_x_r      <= out_x_nxt;
      out_y_r      <= out_y_nxt;
      out_color_r  <= out_color_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_x         = out_x_r;
  assign out_y         = out_y_r;
  assign out_color     = out_color_r;
  assign out_last_item = out_last_r;

  // status back to the controller
  assign sts.cnt_full   = (count_r == CNT_W'(CAPACITY));
  assign sts.cnt_zero   = (count_r == '0);
  assign sts.last_idx   = (idx_inc == count_r);
  assign sts.survive    = survive;
  assign sts.pend_valid = pend_valid_r;
  assign sts.out_free   = out_free;

`ifndef SYNTHESIS
  // fill level never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("particle count above capacity");

  // compaction write pointer never overtakes the read walk
  a_wr_behind: assert property (@(posedge clk) disable iff (!rst_n)
    wr_r <= idx_r)
    else $error("compaction pointer ahead of walk index");

  // a pending survivor is only pushed out into a free output register
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.keep && pend_valid_r) |-> out_free)
    else $error("pending survivor pushed while output busy");

  // the closing beat of a tick is marked last
  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> (out_valid_r && out_last_r))
    else $error("tick closed without a last beat");
`endif

endmodule

### bench/ptu_checker.sv
// ---------------------------------------------------------------------------
// ptu_checker: result predictor and scoreboard for particle_table_update
// Watches both channels, keeps its own copy of the particle table, queues
// the beats each accepted action must produce and compares every result
// beat against the oldest one still due.
// ---------------------------------------------------------------------------
module ptu_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [31:0]        in_now_ms,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_vel_x,
  input  logic signed [15:0] in_vel_y,
  input  logic [15:0]        in_life_ms,
  input  logic [31:0]        in_part_color,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         out_status,
  input  logic signed [15:0] out_x,
  input  logic signed [15:0] out_y,
  input  logic [31:0]        out_color,
  input  logic               out_last_item,
  output int                 mismatch_count,
  output int                 beats_left
);
  timeunit 1ns;
  timeprecision 1ps;
  import ptu_pkg::*;

  // one result beat as the block should send it
  typedef struct packed {
    ptu_result_t status;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] color;
    logic        last;
  } part_beat_t;

  // shadow particle table
  logic [15:0] tab_x     [CAPACITY];
  logic [15:0] tab_y     [CAPACITY];
  logic [15:0] tab_vx    [CAPACITY];
  logic [15:0] tab_vy    [CAPACITY];
  logic [15:0] tab_life  [CAPACITY];
  logic [31:0] tab_birth [CAPACITY];
  logic [31:0] tab_color [CAPACITY];
  int          fill_level = 0;

  part_beat_t  beats_due[$];
  int          errors = 0;

  task automatic queue_beat(input ptu_result_t st, input logic [15:0] x,
                            input logic [15:0] y, input logic [31:0] color,
                            input logic last);
    part_beat_t b;
    b.status = st;
    b.x      = x;
    b.y      = y;
    b.color  = color;
    b.last   = last;
    beats_due.push_back(b);
  endtask

  // advance the shadow table by one action and queue its result beats
  task automatic apply_action(input logic [1:0] act, input logic [31:0] now,
                              input logic [15:0] px, input logic [15:0] py,
                              input logic [15:0] vx, input logic [15:0] vy,
                              input logic [15:0] life, input logic [31:0] color);
    int          kept;
    logic [32:0] expiry;
    case (act)
      ACT_ADD: begin
        if (fill_level < CAPACITY) begin
          tab_x[fill_level]     = px;
          tab_y[fill_level]     = py;
          tab_vx[fill_level]    = vx;
          tab_vy[fill_level]    = vy;
          tab_life[fill_level]  = life;
          tab_birth[fill_level] = now;
          tab_color[fill_level] = color;
          fill_level++;
          queue_beat(RES_ADDED, '0, '0, '0, 1'b1);
        end else begin
          queue_beat(RES_FULL, '0, '0, '0, 1'b1);
        end
      end
      ACT_CLEAR: begin
        fill_level = 0;
        queue_beat(RES_CLEARED, '0, '0, '0, 1'b1);
      end
      ACT_TICK: begin
        kept = 0;
        // move, drop the expired ones and pack survivors to the front
        for (int i = 0; i < fill_level; i++) begin
          expiry = {1'b0, tab_birth[i]} + {17'b0, tab_life[i]};
          if ({1'b0, now} > expiry) continue;
          tab_x[kept]     = tab_x[i] + tab_vx[i];
          tab_y[kept]     = tab_y[i] + tab_vy[i];
          tab_vx[kept]    = tab_vx[i];
          tab_vy[kept]    = tab_vy[i];
          tab_life[kept]  = tab_life[i];
          tab_birth[kept] = tab_birth[i];
          tab_color[kept] = tab_color[i];
          kept++;
        end
        fill_level = kept;
        if (kept == 0) begin
          queue_beat(RES_NONE, '0, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < kept; i++)
            queue_beat(RES_LIVE, tab_x[i], tab_y[i], tab_color[i], i == kept - 1);
        end
      end
      default: ; // unused code: no state change, no result
    endcase
  endtask

  // compare one result beat with the oldest one due
  task automatic check_beat();
    part_beat_t exp_b;
    if (beats_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: unexpected beat status %0d x %0d y %0d color %h last %b",
                 out_status, out_x, out_y, out_color, out_last_item);
      return;
    end
    exp_b = beats_due.pop_front();
    if (out_status !== exp_b.status || out_x !== exp_b.x || out_y !== exp_b.y ||
        out_color !== exp_b.color || out_last_item !== exp_b.last) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: exp status %0d x %0d y %0d color %h last %b, got %0d %0d %0d %h %b",
                 exp_b.status, $signed(exp_b.x), $signed(exp_b.y), exp_b.color,
                 exp_b.last, out_status, out_x, out_y, out_color, out_last_item);
    end
  endtask

  // check results before predicting, so a beat never matches its own action
  always @(posedge clk) begin
    if (!rst_n) begin
      beats_due.delete();
      fill_level = 0;
    end else begin
      if (out_valid && !out_stall)
        check_beat();
      if (in_valid && !in_stall)
        apply_action(in_action, in_now_ms, in_pos_x, in_pos_y, in_vel_x, in_vel_y,
                     in_life_ms, in_part_color);
    end
    mismatch_count <= errors;
    beats_left     <= beats_due.size();
  end

endmodule

### bench/tb_particle_table_update.sv
// ---------------------------------------------------------------------------
// tb_particle_table_update: testbench top for the particle table
// Drives a directed run over the field extremes, expiry edges and every
// action, then random add/tick/clear sequences with random idle and stall
// bursts; the checker predicts and compares, this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_particle_table_update;
  timeunit 1ns;
  timeprecision 1ps;
  import ptu_pkg::*;

  localparam logic [1:0] ACT_UNUSED     = 2'd3;
  localparam int         RANDOM_ITEMS   = 200;
  localparam int         QUIET_TAIL     = 40;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         DRAIN_CYCLES   = 100;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_action;
  logic [31:0]        in_now_ms;
  logic signed [15:0] in_pos_x;
  logic signed [15:0] in_pos_y;
  logic signed [15:0] in_vel_x;
  logic signed [15:0] in_vel_y;
  logic [15:0]        in_life_ms;
  logic [31:0]        in_part_color;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         out_status;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic [31:0]        out_color;
  logic               out_last_item;
  int                 mismatch_count;
  int                 beats_left;

  bit                 idle_on;
  int                 items_sent;
  logic [31:0]        clock_ms;
  int                 idle_cycles;

  particle_table_update dut (.*);
  ptu_checker           checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // send one action beat, with an optional idle burst ahead of it
  task automatic send_beat(input logic [1:0] act, input logic [31:0] now,
                           input logic [15:0] px, input logic [15:0] py,
                           input logic [15:0] vx, input logic [15:0] vy,
                           input logic [15:0] life, input logic [31:0] color);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_now_ms     <= now;
    in_pos_x      <= px;
    in_pos_y      <= py;
    in_vel_x      <= vx;
    in_vel_y      <= vy;
    in_life_ms    <= life;
    in_part_color <= color;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act != ACT_UNUSED) items_sent++;
  endtask

  task automatic send_add(input logic [31:0] now, input logic [15:0] life);
    send_beat(ACT_ADD, now, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), life, $urandom);
  endtask

  task automatic send_other(input logic [1:0] act, input logic [31:0] now);
    send_beat(act, now, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), $urandom);
  endtask

  // mostly short lives so expiry happens, some long and some near zero
  function automatic logic [15:0] pick_life();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 16'($urandom_range(0, 1500));
    if (r < 9) return 16'($urandom);
    return 16'($urandom_range(0, 20));
  endfunction

  // result side: random stall bursts while idling is on
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && rst_n && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // end the run if nothing moves on either channel for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAIL particle_table_update");
    $finish;
  end

  initial begin
    int  pick;
    int  burst;
    bit  first_seq;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_action     <= ACT_ADD;
    in_now_ms     <= '0;
    in_pos_x      <= '0;
    in_pos_y      <= '0;
    in_vel_x      <= '0;
    in_vel_y      <= '0;
    in_life_ms    <= '0;
    in_part_color <= '0;
    idle_on       = 1'b1;
    items_sent    = 0;
    clock_ms      = $urandom_range(0, 100000);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, unused code, extremes, expiry boundaries
    send_other(ACT_TICK, 32'd0);
    send_other(ACT_CLEAR, 32'd0);
    send_other(ACT_UNUSED, 32'hFFFF_FFFF);
    send_beat(ACT_ADD, 32'd0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'd0,
              32'hFFFF_FFFF);
    send_beat(ACT_ADD, 32'hFFFF_FFFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001,
              16'hFFFF, 32'h0000_0000);
    send_beat(ACT_ADD, 32'd100, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 16'd10,
              32'h5A5A_A5A5);
    send_other(ACT_TICK, 32'd0);             // all live, positions wrap
    send_other(ACT_TICK, 32'd1);             // zero-life particle expires
    send_other(ACT_TICK, 32'd110);           // exactly at birth plus life: kept
    send_other(ACT_TICK, 32'd111);           // one past: dropped
    send_other(ACT_TICK, 32'hFFFF_FFFF);     // birth plus life beyond 32 bits: kept
    send_other(ACT_UNUSED, 32'd0);
    send_other(ACT_TICK, 32'hFFFF_FFFF);
    send_other(ACT_CLEAR, 32'hFFFF_FFFF);
    send_other(ACT_TICK, 32'd0);
    send_beat(ACT_ADD, 32'hA5A5_5A5A, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
              16'h8000, 32'h1234_5678);
    send_other(ACT_TICK, 32'hA5A5_5A5A);
    send_other(ACT_CLEAR, 32'd0);

    // random: add bursts followed by ticks most often, on an advancing clock
    items_sent = 0;
    first_seq  = 1'b1;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= RANDOM_ITEMS - QUIET_TAIL) idle_on = 1'b0;
      else if ($urandom_range(0, 9) == 0) idle_on = ($urandom_range(0, 3) != 0);
      pick      = first_seq ? 80 : $urandom_range(0, 99);
      first_seq = 1'b0;
      if (pick < 45) begin
        burst = $urandom_range(1, 8);
        repeat (burst) begin
          clock_ms += $urandom_range(0, 150);
          send_add(clock_ms, pick_life());
        end
        repeat ($urandom_range(1, 3)) begin
          clock_ms += $urandom_range(0, 400);
          send_other(ACT_TICK, clock_ms);
        end
      end else if (pick < 65) begin
        repeat ($urandom_range(1, 3)) begin
          clock_ms += $urandom_range(0, 400);
          send_other(ACT_TICK, clock_ms);
        end
      end else if (pick < 75) begin
        send_other(ACT_CLEAR, clock_ms);
      end else if (pick < 85) begin
        // fill to capacity and beyond, then walk the full table
        send_other(ACT_CLEAR, clock_ms);
        repeat (CAPACITY + $urandom_range(1, 3)) begin
          clock_ms += $urandom_range(0, 20);
          send_add(clock_ms, ($urandom_range(0, 1) != 0) ? 16'($urandom) : pick_life());
        end
        clock_ms += $urandom_range(0, 300);
        send_other(ACT_TICK, clock_ms);
      end else if (pick < 92) begin
        clock_ms = $urandom;
        send_other(ACT_TICK, clock_ms);
      end else if (pick < 96) begin
        send_other(ACT_UNUSED, $urandom);
      end else begin
        send_other(ACT_TICK, $urandom);
      end
    end

    // drain: wait for every due beat, then let the block settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && beats_left == 0)
      $display("PASS particle_table_update");
    else
      $display("FAIL particle_table_update");
    $finish;
  end

endmodule
